FILE: hw/rtl/bvfa_pkg.sv
// ---------------------------------------------------------------------------
// bvfa_pkg
// Shared types, command codes and command decode for the byte variable
// file alu.
// ---------------------------------------------------------------------------
package bvfa_pkg;

    // command codes carried in req_type
    localparam logic [3:0] OP_INC      = 4'd0;
    localparam logic [3:0] OP_DEC      = 4'd1;
    localparam logic [3:0] OP_SET_IMM  = 4'd2;
    localparam logic [3:0] OP_SET_VAR  = 4'd3;
    localparam logic [3:0] OP_ADD_IMM  = 4'd4;
    localparam logic [3:0] OP_ADD_VAR  = 4'd5;
    localparam logic [3:0] OP_SUB_IMM  = 4'd6;
    localparam logic [3:0] OP_SUB_VAR  = 4'd7;
    localparam logic [3:0] OP_STI_VAR  = 4'd8;
    localparam logic [3:0] OP_STI_IMM  = 4'd9;
    localparam logic [3:0] OP_LDI      = 4'd10;
    localparam logic [3:0] OP_MUL_IMM  = 4'd11;
    localparam logic [3:0] OP_MUL_VAR  = 4'd12;
    localparam logic [3:0] OP_DIV_IMM  = 4'd13;
    localparam logic [3:0] OP_DIV_VAR  = 4'd14;

    // operations of the shared arithmetic unit
    typedef logic [2:0] t_alu_kind;
    localparam t_alu_kind K_MOV = 3'd0;
    localparam t_alu_kind K_INC = 3'd1;
    localparam t_alu_kind K_DEC = 3'd2;
    localparam t_alu_kind K_ADD = 3'd3;
    localparam t_alu_kind K_SUB = 3'd4;
    localparam t_alu_kind K_MUL = 3'd5;
    localparam t_alu_kind K_DIV = 3'd6;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic      start;
        t_alu_kind kind;
        logic [7:0] x;
        logic [7:0] y;
    } t_alu_req;

    // response from the arithmetic unit
    typedef struct packed {
        logic       done;
        logic       dz;
        logic [7:0] result;
    } t_alu_rsp;

    // per command control
    typedef struct packed {
        t_alu_kind kind;
        logic      use_var;   // second operand is a variable value
        logic      y_cur;     // second operand is the target value itself
        logic      ind_tgt;   // target index is the value of the first variable
        logic      dbl_read;  // source index is the value of a variable
        logic      wr_en;     // command writes the file
    } t_cmd_ctrl;

    function automatic t_cmd_ctrl cmd_decode(input logic [3:0] op);
        t_cmd_ctrl c;
        c.kind     = K_MOV;
        c.use_var  = 1'b0;
        c.y_cur    = 1'b0;
        c.ind_tgt  = 1'b0;
        c.dbl_read = 1'b0;
        c.wr_en    = 1'b1;
        case (op)
            OP_INC:     c.kind = K_INC;
            OP_DEC:     c.kind = K_DEC;
            OP_SET_IMM: c.kind = K_MOV;
            OP_SET_VAR: c.use_var = 1'b1;
            OP_ADD_IMM: c.kind = K_ADD;
            OP_ADD_VAR: begin
                c.kind    = K_ADD;
                c.use_var = 1'b1;
            end
            OP_SUB_IMM: c.kind = K_SUB;
            OP_SUB_VAR: begin
                c.kind    = K_SUB;
                c.use_var = 1'b1;
            end
            OP_STI_VAR: begin
                c.use_var = 1'b1;
                c.ind_tgt = 1'b1;
            end
            OP_STI_IMM: c.ind_tgt = 1'b1;
            OP_LDI: begin
                c.use_var  = 1'b1;
                c.dbl_read = 1'b1;
            end
            OP_MUL_IMM: c.kind = K_MUL;
            OP_MUL_VAR: begin
                c.kind    = K_MUL;
                c.use_var = 1'b1;
            end
            OP_DIV_IMM: c.kind = K_DIV;
            OP_DIV_VAR: begin
                c.kind    = K_DIV;
                c.use_var = 1'b1;
            end
            default: begin
                // unused code: report the target unchanged
                c.y_cur = 1'b1;
                c.wr_en = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/bvfa_varfile.sv
// ---------------------------------------------------------------------------
// bvfa_varfile
// 256 x 8 variable file, one write and one registered read per cycle;
// per-entry valid bits make every entry read as zero after reset.
// ---------------------------------------------------------------------------
module bvfa_varfile (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rd_addr,
    output logic [7:0] o_rd_data,
    input  logic       i_wr_en,
    input  logic [7:0] i_wr_addr,
    input  logic [7:0] i_wr_data
);

    logic [7:0]   r_mem [256];
    logic [255:0] r_valid;
    logic [7:0]   r_rd_data;
    logic         r_rd_vld;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : 8'h00;

endmodule

FILE: hw/rtl/bvfa_alu.sv
// ---------------------------------------------------------------------------
// bvfa_alu
// Shared arithmetic unit built around one adder/subtractor: single-step
// add, subtract and saturating inc/dec, eight-step shift-add multiply and
// eight-step restoring divide.
// ---------------------------------------------------------------------------
module bvfa_alu
    import bvfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic       r_dz, n_dz;
    t_alu_kind  r_kind, n_kind;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_acc, n_acc;
    logic [7:0] r_sh, n_sh;
    logic [7:0] r_y, n_y;

    logic [8:0] w_opa;
    logic [8:0] w_opb;
    logic       w_sub;
    logic [9:0] w_sum;

    // operand select for the shared adder
    always_comb begin
        w_opa = {1'b0, r_acc};
        w_opb = {1'b0, r_y};
        w_sub = 1'b0;
        case (r_kind)
            K_MUL: w_opb = {1'b0, r_sh};
            K_DIV: begin
                w_opa = {r_acc, r_sh[7]};
                w_sub = 1'b1;
            end
            K_SUB: w_sub = 1'b1;
            K_INC: w_opb = 9'd1;
            K_DEC: begin
                w_opb = 9'd1;
                w_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // shared adder, carry out set means no borrow on subtract
    assign w_sum = {1'b0, w_opa} + {1'b0, w_opb ^ {9{w_sub}}} + {9'd0, w_sub};

    // step control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_dz   = r_dz;
        n_kind = r_kind;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_y    = r_y;
        if (i_req.start) begin
            n_dz   = 1'b0;
            n_kind = i_req.kind;
            n_cnt  = 3'd0;
            n_acc  = i_req.x;
            n_sh   = i_req.x;
            n_y    = i_req.y;
            n_busy = 1'b1;
            if (i_req.kind == K_MUL) begin
                n_acc = 8'h00;
            end else if (i_req.kind == K_DIV) begin
                n_acc = 8'h00;
                if (i_req.y == 8'h00) begin
                    // zero divisor: finish at once with the target value
                    n_dz   = 1'b1;
                    n_kind = K_MOV;
                    n_acc  = i_req.x;
                    n_y    = i_req.x;
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end else if (r_busy) begin
            n_busy = 1'b0;
            n_done = 1'b1;
            case (r_kind)
                K_MUL: begin
                    if (r_y[0]) begin
                        n_acc = w_sum[7:0];
                    end
                    n_sh  = {r_sh[6:0], 1'b0};
                    n_y   = {1'b0, r_y[7:1]};
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt != 3'd7) begin
                        n_busy = 1'b1;
                        n_done = 1'b0;
                    end
                end
                K_DIV: begin
                    if (w_sum[9]) begin
                        n_acc = w_sum[7:0];
                    end else begin
                        n_acc = w_opa[7:0];
                    end
                    n_sh  = {r_sh[6:0], w_sum[9]};
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt != 3'd7) begin
                        n_busy = 1'b1;
                        n_done = 1'b0;
                    end
                end
                K_ADD, K_SUB: n_acc = w_sum[7:0];
                K_INC: begin
                    if (r_acc != 8'hFF) begin
                        n_acc = w_sum[7:0];
                    end
                end
                K_DEC: begin
                    if (r_acc != 8'h00) begin
                        n_acc = w_sum[7:0];
                    end
                end
                default: n_acc = r_y;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dz   <= n_dz;
        r_kind <= n_kind;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_sh   <= n_sh;
        r_y    <= n_y;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.dz     = r_dz;
    assign o_rsp.result = (r_kind == K_DIV) ? r_sh : r_acc;

endmodule

FILE: hw/rtl/byte_variable_file_alu_unit.sv
// ---------------------------------------------------------------------------
// byte_variable_file_alu_unit
// Runs one arithmetic command per item against a file of 256 byte variables
// and reports the index written and its new value.
// ---------------------------------------------------------------------------
// One item at a time: the next item can be accepted in the cycle after the
// result is loaded. The time per item is set by the serial reads through the
// one read port of the variable file (target, source, and the extra hop of
// load-indirect) and by the eight-step shift-add multiply and restoring
// divide of the one shared adder. The result sits in an output register, so
// a new item is taken while it waits. The file reads as all zero right after
// reset; no clearing pass is needed.
module byte_variable_file_alu_unit
    import bvfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_req_type,
    input  logic [7:0] i_first_operand,
    input  logic [7:0] i_second_operand,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_written_index,
    output logic [7:0] o_written_value,
    output logic       o_divide_by_zero
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_RDC  = 3'd3;
    localparam logic [2:0] S_EXEC = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [3:0] r_op;
    logic [7:0] r_a, r_b, r_cur, r_vb, r_val;
    logic       r_dz;
    logic       r_out_valid;
    logic [7:0] r_out_index, r_out_value;
    logic       r_out_dz;

    t_cmd_ctrl  w_ctrl;
    t_alu_req   w_alu_req;
    t_alu_rsp   w_alu_rsp;
    logic [7:0] w_rd_addr;
    logic [7:0] w_rd_data;
    logic       w_wr_en;
    logic [7:0] w_tgt;
    logic       w_accept;
    logic       w_out_free;

    assign w_ctrl     = cmd_decode(r_op);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_tgt      = w_ctrl.ind_tgt ? r_cur : r_a;
    assign w_wr_en    = (r_state == S_WR) && w_out_free && w_ctrl.wr_en && !r_dz;

    bvfa_varfile u_varfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_tgt),
        .i_wr_data (r_val)
    );

    bvfa_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .o_rsp   (w_alu_rsp)
    );

    // read address per sequencer step
    always_comb begin
        w_rd_addr = r_a;
        case (r_state)
            S_IDLE: w_rd_addr = i_first_operand;
            S_RDA:  w_rd_addr = r_b;
            S_RDB:  w_rd_addr = w_rd_data;
            default: ;
        endcase
    end

    // arithmetic request
    always_comb begin
        w_alu_req.start = (r_state == S_EXEC);
        w_alu_req.kind  = w_ctrl.kind;
        w_alu_req.x     = r_cur;
        if (w_ctrl.use_var) begin
            w_alu_req.y = r_vb;
        end else if (w_ctrl.y_cur) begin
            w_alu_req.y = r_cur;
        end else begin
            w_alu_req.y = r_b;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RDA;
                end
            end
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = w_ctrl.dbl_read ? S_RDC : S_EXEC;
            S_RDC:  n_state = S_EXEC;
            S_EXEC: n_state = S_WAIT;
            S_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_WR) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item operands, fetched values and result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_req_type;
            r_a  <= i_first_operand;
            r_b  <= i_second_operand;
        end
        if (r_state == S_RDA) begin
            r_cur <= w_rd_data;
        end
        if ((r_state == S_RDB) || (r_state == S_RDC)) begin
            r_vb <= w_rd_data;
        end
        if ((r_state == S_WAIT) && w_alu_rsp.done) begin
            r_val <= w_alu_rsp.result;
            r_dz  <= w_alu_rsp.dz;
        end
        if ((r_state == S_WR) && w_out_free) begin
            r_out_index <= w_tgt;
            r_out_value <= r_val;
            r_out_dz    <= r_dz;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_written_index  = r_out_index;
    assign o_written_value  = r_out_value;
    assign o_divide_by_zero = r_out_dz;

`ifndef NO_ASSERTIONS
    // an accepted item blocks the next one
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // the arithmetic unit answers only while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> (r_state == S_WAIT))
        else $error("arithmetic unit done outside the wait step");

    // zero-divisor flag only for divide commands
    a_dz_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WAIT) && w_alu_rsp.done && w_alu_rsp.dz)
            |-> ((r_op == OP_DIV_IMM) || (r_op == OP_DIV_VAR)))
        else $error("divide by zero flag on a non-divide command");

    // the file is written only when the result is loaded
    a_write_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("variable written without a result");
`endif

endmodule

FILE: verif/byte_variable_file_alu_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// byte_variable_file_alu_checker
// Watches both channels of the byte variable file alu. Keeps its own copy of
// the 256-entry variable file, works out the write report of every accepted
// item and compares each accepted result with the oldest report waiting.
// ---------------------------------------------------------------------------
module byte_variable_file_alu_checker
    import bvfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [3:0] i_req_type,
    input  logic [7:0] i_first_operand,
    input  logic [7:0] i_second_operand,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_written_index,
    input  logic [7:0] i_written_value,
    input  logic       i_divide_by_zero,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [7:0] BYTE_MAX = 8'hFF;
    localparam logic [7:0] BYTE_MIN = 8'h00;

    typedef struct packed {
        logic [7:0] idx;
        logic [7:0] value;
        logic       dz;
    } t_write_report;

    logic [7:0]    var_file [256];
    t_write_report report_queue [$];

    // run one command against the local variable file
    function automatic t_write_report exec_command(input logic [3:0] op,
                                                   input logic [7:0] a,
                                                   input logic [7:0] b);
        t_write_report rep;
        logic [7:0]    tgt;
        logic [7:0]    cur;
        logic [7:0]    val;
        logic [7:0]    src;
        logic [7:0]    divisor;
        logic          wr;
        tgt    = a;
        cur    = var_file[a];
        src    = var_file[b];
        val    = cur;
        wr     = 1'b1;
        rep.dz = 1'b0;
        case (op)
            OP_INC:     if (cur != BYTE_MAX) val = cur + 8'd1;
            OP_DEC:     if (cur != BYTE_MIN) val = cur - 8'd1;
            OP_SET_IMM: val = b;
            OP_SET_VAR: val = src;
            OP_ADD_IMM: val = cur + b;
            OP_ADD_VAR: val = cur + src;
            OP_SUB_IMM: val = cur - b;
            OP_SUB_VAR: val = cur - src;
            OP_STI_VAR: begin
                tgt = cur;
                val = src;
            end
            OP_STI_IMM: begin
                tgt = cur;
                val = b;
            end
            OP_LDI:     val = var_file[src];
            OP_MUL_IMM: val = 8'(cur * b);
            OP_MUL_VAR: val = 8'(cur * src);
            OP_DIV_IMM, OP_DIV_VAR: begin
                divisor = (op == OP_DIV_IMM) ? b : src;
                if (divisor == BYTE_MIN) begin
                    rep.dz = 1'b1;
                    wr     = 1'b0;
                end else begin
                    val = cur / divisor;
                end
            end
            default:    wr = 1'b0;
        endcase
        if (wr) var_file[tgt] = val;
        rep.idx   = tgt;
        rep.value = var_file[tgt];
        return rep;
    endfunction

    // channel monitor: compare results, then predict newly accepted items
    always @(posedge i_clk) begin
        t_write_report want;
        if (!i_rst_n) begin
            for (int i = 0; i < 256; i++) var_file[i] = BYTE_MIN;
            report_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (report_queue.size() == 0) begin
                    $error("result with no item pending: index %0d value %0d",
                           i_written_index, i_written_value);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = report_queue.pop_front();
                    if (i_written_index !== want.idx) begin
                        $error("written_index: expected %0d, got %0d",
                               want.idx, i_written_index);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_written_value !== want.value) begin
                        $error("written_value: expected %0d, got %0d",
                               want.value, i_written_value);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_divide_by_zero !== want.dz) begin
                        $error("divide_by_zero: expected %0d, got %0d",
                               want.dz, i_divide_by_zero);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                report_queue.push_back(exec_command(i_req_type, i_first_operand,
                                                    i_second_operand));
        end
        o_pending = report_queue.size();
    end

endmodule

FILE: verif/byte_variable_file_alu_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// byte_variable_file_alu_unit_tb
// Drives directed and random command items into the byte variable file alu
// with random gaps on both channels and one long output hold-off, and takes
// the verdict from the checker that runs beside the block.
// ---------------------------------------------------------------------------
module byte_variable_file_alu_unit_tb;
    import bvfa_pkg::*;

    localparam logic [3:0] OP_UNUSED   = 4'd15;
    localparam int         RAND_ITEMS  = 1200;
    localparam int         PHASES      = 4;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_CYCLES = 40;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [3:0] i_req_type;
    logic [7:0] i_first_operand;
    logic [7:0] i_second_operand;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_written_index;
    logic [7:0] o_written_value;
    logic       o_divide_by_zero;
    int         fail_count;
    int         pending;

    bit         gaps_on;
    bit         long_hold;

    byte_variable_file_alu_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_written_index  (o_written_index),
        .o_written_value  (o_written_value),
        .o_divide_by_zero (o_divide_by_zero)
    );

    byte_variable_file_alu_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_written_index  (o_written_index),
        .i_written_value  (o_written_value),
        .i_divide_by_zero (o_divide_by_zero),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // operand byte: small indices and edges often, full range otherwise
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'($urandom_range(0, 7));
        if (r < 45) return 8'hFF;
        if (r < 50) return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one item after a random gap and wait until it is taken
    task automatic send_cmd(input logic [3:0] op, input logic [7:0] a,
                            input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= op;
        i_first_operand  <= a;
        i_second_operand <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin : out_stall_gen
        int n;
        repeat (13) @(negedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(negedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_req_type       = OP_INC;
        i_first_operand  = 8'h00;
        i_second_operand = 8'h00;
        i_out_stall      = 1'b0;
        gaps_on          = 1'b1;
        long_hold        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every command, saturation, wrap, indirect forms, zero divide
        send_cmd(OP_INC,     8'd0,   8'hFF);
        send_cmd(OP_SET_IMM, 8'd5,   8'hFF);
        send_cmd(OP_INC,     8'd5,   8'h00);
        send_cmd(OP_DEC,     8'd6,   8'hFF);
        send_cmd(OP_DEC,     8'd5,   8'h00);
        send_cmd(OP_SET_IMM, 8'd255, 8'd200);
        send_cmd(OP_ADD_IMM, 8'd255, 8'd100);
        send_cmd(OP_ADD_VAR, 8'd5,   8'd255);
        send_cmd(OP_SUB_IMM, 8'd6,   8'd1);
        send_cmd(OP_SUB_VAR, 8'd0,   8'd5);
        send_cmd(OP_SET_VAR, 8'd7,   8'd6);
        send_cmd(OP_SET_IMM, 8'd10,  8'd20);
        send_cmd(OP_SET_IMM, 8'd11,  8'd77);
        send_cmd(OP_STI_VAR, 8'd10,  8'd11);
        send_cmd(OP_STI_IMM, 8'd10,  8'hFF);
        send_cmd(OP_SET_IMM, 8'd30,  8'd20);
        send_cmd(OP_LDI,     8'd31,  8'd30);
        send_cmd(OP_MUL_IMM, 8'd5,   8'hFF);
        send_cmd(OP_MUL_VAR, 8'd31,  8'd5);
        send_cmd(OP_DIV_IMM, 8'd5,   8'h00);
        send_cmd(OP_DIV_IMM, 8'd5,   8'd7);
        send_cmd(OP_DIV_VAR, 8'd31,  8'd100);
        send_cmd(OP_DIV_VAR, 8'd6,   8'd5);
        send_cmd(OP_UNUSED,  8'd6,   8'hFF);
        send_cmd(OP_UNUSED,  8'd200, 8'h00);

        // random phases: no gaps, gaps, gaps with a long output hold, gaps
        for (int p = 0; p < PHASES; p++) begin
            gaps_on = (p != 0);
            if (p == 2) long_hold = 1'b1;
            for (int k = 0; k < RAND_ITEMS / PHASES; k++)
                send_cmd(4'($urandom_range(0, 15)), pick_byte(), pick_byte());
        end
        i_in_valid <= 1'b0;

        // drain
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
